@@ hdl/crspe_pkg.sv @@
// ----------------------------------------------------------------------------
// crspe_pkg: shared types and constants of the Catmull-Rom point evaluator
// Request and result payloads, status codes, and arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package crspe_pkg;

    // Default capacity of the control point store.
    localparam int MAX_POINTS_DEF = 256;

    // A curve needs at least this many points to be evaluated.
    localparam int MIN_POINTS = 4;

    // Curve parameter is unsigned Q1.16.
    localparam int T_W    = 17;
    localparam int FRAC_W = 16;
    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

    // Width of the Horner intermediates. The doubled coefficients reach about
    // twelve times the coordinate range, and each Horner step adds at most one
    // more coefficient, so 38 signed bits hold every intermediate exactly.
    localparam int HW = 38;

    // Request action codes.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_T_HIGH     = 2'd1,
        ST_FEW_POINTS = 2'd2,
        ST_BAD_INDEX  = 2'd3
    } t_status;

    typedef struct packed {
        logic               action;
        logic [8:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [T_W-1:0]     curve_param;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         status;
    } t_out_res;

    // One stored control point.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    // Segment context that travels beside the store read data.
    typedef struct packed {
        logic [1:0]     rbase;  // low bits of the first window index
        logic           lo;     // first neighbor clamped to the start
        logic           hi;     // last neighbor clamped to the end
        logic [T_W-1:0] u;      // local fraction, unsigned Q1.16, up to exactly one
    } t_win;

    // Register load enables of the arithmetic stages.
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_adv;

endpackage

`default_nettype wire

@@ hdl/catmull_rom_spline_point_evaluator_top.sv @@
// Throughput: one request per cycle while the result side does not stall; the six-stage
// pipeline and the four-bank point store, one read per bank, let every cycle take a request.
// Reset: synchronous, active low; clears the stage valid bits and point_count.
// The point store is not cleared; a point reads as undefined until loaded.
// ----------------------------------------------------------------------------
// catmull_rom_spline_point_evaluator_top: uniform Catmull-Rom point evaluator
// Loads 3D control points into a banked store and evaluates the uniform
// Catmull-Rom spline through them at a curve parameter t in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_spline_point_evaluator_top #(
    parameter int MAX_POINTS = crspe_pkg::MAX_POINTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Request channel.
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire crspe_pkg::t_in_req  i_in_req,
    // Result channel.
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output crspe_pkg::t_out_res      o_out_res,
    // Configuration write channel: point_count.
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [8:0]          i_cfg_data
);
    import crspe_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int S_W   = T_W + IDX_W;
    localparam int EXT_W = (IDX_W > 9) ? IDX_W : 9;

    // ------------------------------------------------------------------
    // Pipeline flow control.
    // Each stage holds a valid bit. A stage takes new contents when it is
    // empty or when the stage after it moves on, so bubbles are squeezed
    // out during a stall and nothing is dropped or repeated. Stage 6 is
    // the output register.
    // ------------------------------------------------------------------
    logic [6:1] r_vld;
    logic [6:1] w_rdy;

    always_comb begin
        w_rdy[6] = !r_vld[6] || !i_out_stall;
        for (int k = 5; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_stall = !w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration register. Always ready; the user must write it only while idle (not enforced here).
    // ------------------------------------------------------------------
    logic [8:0] r_point_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: status checks and the segment scale s = t * (count - 1).
    // A count above the store capacity is taken as the capacity.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] cnt_eff, cnt_m1;
    logic [IDX_W-1:0] seg_n;
    logic [EXT_W-1:0] slot_ext;
    logic [S_W-1:0]   n_s1_s;
    t_status          n_s1_st;
    logic             n_s1_ok;

    logic             r_s1_act;
    logic [IDX_W-1:0] r_s1_slot;
    t_point           r_s1_pt;
    logic [S_W-1:0]   r_s1_s;
    logic [IDX_W-1:0] r_s1_n;

    t_status          r_st [1:6];
    logic [6:1]       r_ok;

    always_comb begin
        if (int'(r_point_count) > MAX_POINTS) begin
            cnt_eff = CNT_W'(MAX_POINTS);
        end else begin
            cnt_eff = CNT_W'(r_point_count);
        end
        cnt_m1   = cnt_eff - CNT_W'(1);
        seg_n    = cnt_m1[IDX_W-1:0];
        n_s1_s   = S_W'(i_in_req.curve_param) * S_W'(seg_n);
        slot_ext = EXT_W'(i_in_req.point_index);

        // Parameter range is checked before the point count.
        if (i_in_req.action == ACT_LOAD) begin
            n_s1_st = (int'(i_in_req.point_index) >= MAX_POINTS) ? ST_BAD_INDEX : ST_OK;
        end else if (i_in_req.curve_param > ONE_Q16) begin
            n_s1_st = ST_T_HIGH;
        end else if (cnt_eff < CNT_W'(MIN_POINTS)) begin
            n_s1_st = ST_FEW_POINTS;
        end else begin
            n_s1_st = ST_OK;
        end
        // Only a successful evaluation carries nonzero coordinates.
        n_s1_ok = (i_in_req.action == ACT_EVAL) && (n_s1_st == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_act  <= i_in_req.action;
            r_s1_slot <= slot_ext[IDX_W-1:0];
            r_s1_pt   <= '{x: i_in_req.point_x, y: i_in_req.point_y, z: i_in_req.point_z};
            r_s1_s    <= n_s1_s;
            r_s1_n    <= seg_n;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: segment index and fraction, neighbor clamps, store access.
    // Past the last segment the index is pulled back to n-1 with u = 1.
    // Loads write the store on the same edge that evaluations read it, so
    // an evaluation always sees every load that came before it.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] idx_raw, n_ext, nm1, idx, rbase;
    t_win             n_s2_win;
    t_win             r_s2_win;
    logic             we;
    t_point [3:0]     bank;

    always_comb begin
        idx_raw = r_s1_s[S_W-1:FRAC_W];
        n_ext   = CNT_W'(r_s1_n);
        nm1     = n_ext - CNT_W'(1);
        if (idx_raw > nm1) begin
            idx        = nm1;
            n_s2_win.u = ONE_Q16;
        end else begin
            idx        = idx_raw;
            n_s2_win.u = {1'b0, r_s1_s[FRAC_W-1:0]};
        end
        // First window point is idx-1; at idx 0 it wraps and is replaced.
        rbase          = idx - CNT_W'(1);
        n_s2_win.rbase = rbase[1:0];
        n_s2_win.lo    = (idx == '0);
        n_s2_win.hi    = (idx == nm1);
    end

    assign we = w_rdy[2] && r_vld[1] && (r_s1_act == ACT_LOAD) && (r_st[1] == ST_OK);

    crspe_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (w_rdy[2]),
        .i_rd_base  (rbase),
        .i_we       (we),
        .i_wr_slot  (r_s1_slot),
        .i_wr_data  (r_s1_pt),
        .o_bank     (bank)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s2_win <= n_s2_win;
        end
    end

    // Status and zero flag ride along with the data through stages 1..6.
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_st[1] <= n_s1_st;
            r_ok[1] <= n_s1_ok;
        end
        for (int k = 2; k <= 6; k++) begin
            if (w_rdy[k]) begin
                r_st[k] <= r_st[k-1];
                r_ok[k] <= r_ok[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 3..6: one arithmetic lane per coordinate.
    // ------------------------------------------------------------------
    t_adv              adv;
    logic [3:0][31:0]  bank_x, bank_y, bank_z;
    logic signed [31:0] cx, cy, cz;

    assign adv = '{s3: w_rdy[3], s4: w_rdy[4], s5: w_rdy[5], s6: w_rdy[6]};

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            bank_x[b] = bank[b].x;
            bank_y[b] = bank[b].y;
            bank_z[b] = bank[b].z;
        end
    end

    crspe_coord u_coord_x (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_win   (r_s2_win),
        .i_bank  (bank_x),
        .o_coord (cx)
    );

    crspe_coord u_coord_y (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_win   (r_s2_win),
        .i_bank  (bank_y),
        .o_coord (cy)
    );

    crspe_coord u_coord_z (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_win   (r_s2_win),
        .i_bank  (bank_z),
        .o_coord (cz)
    );

    // ------------------------------------------------------------------
    // Result. Loads and failed requests report zero coordinates.
    // ------------------------------------------------------------------
    assign o_out_valid      = r_vld[6];
    assign o_out_res.status = r_st[6];
    assign o_out_res.out_x  = r_ok[6] ? cx : '0;
    assign o_out_res.out_y  = r_ok[6] ? cy : '0;
    assign o_out_res.out_z  = r_ok[6] ? cz : '0;

endmodule

`default_nettype wire

@@ hdl/crspe_store.sv @@
// ----------------------------------------------------------------------------
// crspe_store: four-bank control point store
// Point i lives in bank i mod 4, so any four consecutive points are read
// together, one read per bank. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module crspe_store #(
    parameter int MAX_POINTS = crspe_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rd_en,
    input  wire logic [$clog2(MAX_POINTS):0]   i_rd_base,
    input  wire logic                          i_we,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_wr_slot,
    input  wire crspe_pkg::t_point             i_wr_data,
    output crspe_pkg::t_point [3:0]            o_bank
);
    import crspe_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int BANK_D = (MAX_POINTS + 3) / 4;
    localparam int BA_W   = (BANK_D > 1) ? $clog2(BANK_D) : 1;

    logic [BA_W-1:0] wr_addr;

    assign wr_addr = BA_W'(i_wr_slot >> 2);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        t_point          r_mem [BANK_D];
        t_point          r_rd;
        logic [1:0]      kb;
        logic [IDX_W:0]  rd_idx;
        logic [BA_W-1:0] rd_addr;

        // Which window slot this bank serves, and that slot's point index.
        assign kb      = 2'(b) - i_rd_base[1:0];
        assign rd_idx  = i_rd_base + (IDX_W+1)'(kb);
        assign rd_addr = BA_W'(rd_idx >> 2);

        always_ff @(posedge i_clk) begin
            if (i_we && (i_wr_slot[1:0] == 2'(b))) begin
                r_mem[wr_addr] <= i_wr_data;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                r_rd <= r_mem[rd_addr];
            end
        end

        assign o_bank[b] = r_rd;
    end

endmodule

`default_nettype wire

@@ hdl/crspe_coord.sv @@
// ----------------------------------------------------------------------------
// crspe_coord: Catmull-Rom cubic for one coordinate
// Four stages: doubled coefficients, then three registered Horner steps, the
// last of which also halves, adds the start point and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module crspe_coord (
    input  wire logic               i_clk,
    input  wire crspe_pkg::t_adv    i_adv,
    input  wire crspe_pkg::t_win    i_win,
    input  wire logic [3:0][31:0]   i_bank,
    output logic signed [31:0]      o_coord
);
    import crspe_pkg::*;

    localparam int MW = HW + T_W + 1;

    logic signed [31:0]   e [4];
    logic signed [HW-1:0] p0, p1, p2, p3;
    logic signed [HW-1:0] n_a, n_b, n_c;

    logic signed [HW-1:0] r_s3_a, r_s3_b, r_s3_c, r_s3_p1;
    logic [T_W-1:0]       r_s3_u;
    logic signed [HW-1:0] r_s4_h, r_s4_c, r_s4_p1;
    logic [T_W-1:0]       r_s4_u;
    logic signed [HW-1:0] r_s5_h, r_s5_p1;
    logic [T_W-1:0]       r_s5_u;
    logic signed [31:0]   r_s6_out;

    logic signed [T_W:0]  u3, u4, u5;
    logic signed [MW-1:0] m4, m5, m6;
    logic signed [HW-1:0] n_h4, n_h5, h6, sum6;
    logic signed [31:0]   n_out;

    // Window selection with the end clamps, then the doubled coefficients.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            e[k] = i_bank[i_win.rbase + 2'(k)];
        end
        p0  = i_win.lo ? HW'(e[1]) : HW'(e[0]);
        p1  = HW'(e[1]);
        p2  = HW'(e[2]);
        p3  = i_win.hi ? HW'(e[2]) : HW'(e[3]);
        n_a = (p3 - p0) + ((p1 - p2) <<< 1) + (p1 - p2);
        n_b = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
        n_c = p2 - p0;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_s3_a  <= n_a;
            r_s3_b  <= n_b;
            r_s3_c  <= n_c;
            r_s3_p1 <= p1;
            r_s3_u  <= i_win.u;
        end
    end

    // Horner step one: (A*u) >> 16 + B, floor shift.
    assign u3   = $signed({1'b0, r_s3_u});
    assign m4   = r_s3_a * u3;
    assign n_h4 = $signed(m4[FRAC_W +: HW]) + r_s3_b;

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_s4_h  <= n_h4;
            r_s4_c  <= r_s3_c;
            r_s4_p1 <= r_s3_p1;
            r_s4_u  <= r_s3_u;
        end
    end

    // Horner step two: (h*u) >> 16 + C.
    assign u4   = $signed({1'b0, r_s4_u});
    assign m5   = r_s4_h * u4;
    assign n_h5 = $signed(m5[FRAC_W +: HW]) + r_s4_c;

    always_ff @(posedge i_clk) begin
        if (i_adv.s5) begin
            r_s5_h  <= n_h5;
            r_s5_p1 <= r_s4_p1;
            r_s5_u  <= r_s4_u;
        end
    end

    // Final step: (h*u) >> 16, halve, add the start point, saturate.
    assign u5   = $signed({1'b0, r_s5_u});
    assign m6   = r_s5_h * u5;
    assign h6   = $signed(m6[FRAC_W +: HW]);
    assign sum6 = r_s5_p1 + (h6 >>> 1);

    always_comb begin
        if ((&sum6[HW-1:31]) || !(|sum6[HW-1:31])) begin
            n_out = sum6[31:0];
        end else if (sum6[HW-1]) begin
            n_out = 32'sh8000_0000;
        end else begin
            n_out = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s6) begin
            r_s6_out <= n_out;
        end
    end

    assign o_coord = r_s6_out;

endmodule

`default_nettype wire

@@ hdl/crspe_chk.sv @@
// ----------------------------------------------------------------------------
// crspe_chk: port checker for the Catmull-Rom point evaluator
// Watches the top level ports and flags behavior the design must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module crspe_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire crspe_pkg::t_in_req  i_in_req,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire crspe_pkg::t_out_res o_out_res
);
    import crspe_pkg::*;

    // A stalled request stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_req))
        else $error("stalled request changed or vanished");

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result changed or vanished");

    // Any failed request reports zero coordinates.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_res.status != ST_OK) |->
            (o_out_res.out_x == 0) && (o_out_res.out_y == 0) && (o_out_res.out_z == 0))
        else $error("failed request with nonzero coordinates");

    // With the output register empty, the pipeline can always move.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("request stalled while the output is empty");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind catmull_rom_spline_point_evaluator_top crspe_chk u_crspe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Catmull-Rom spline point evaluator
// Loads control points, moves point_count through several settings, and
// evaluates the curve with directed and random requests. Every result is
// compared field by field against a typed result or an in-bench cycle-free
// predictor, under random idling on both channels and a long result hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import crspe_pkg::*;

    localparam int N_SLOTS     = MAX_POINTS_DEF;
    localparam int LATENCY     = 6;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 3000;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    // Settings of point_count for the random phases, with the number of
    // requests in each. The extremes 0 and 511 are both visited; 511 is
    // above capacity and must behave as a full store.
    localparam int N_PHASES = 9;
    localparam int PHASE_COUNT [N_PHASES] = '{0, 4, 7, 511, 256, 37, 3, 100, 5};
    localparam int PHASE_ITEMS [N_PHASES] = '{20, 40, 50, 70, 60, 80, 20, 60, 40};

    // A result typed in by hand for a directed row; when known is low the
    // predictor supplies the expectation.
    typedef struct packed {
        logic     known;
        t_out_res res;
    } t_hint;

    // One row of the directed table: either a point_count write or a request.
    typedef struct packed {
        logic       is_cfg;
        logic [8:0] cfg;
        t_in_req    req;
        t_hint      hint;
    } t_step;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    t_in_req    req_data;
    logic       res_valid;
    logic       res_stall;
    t_out_res   res_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [8:0] cfg_data;

    // Predictor state: its own copy of the point store and of point_count.
    logic signed [31:0] store_px [N_SLOTS];
    logic signed [31:0] store_py [N_SLOTS];
    logic signed [31:0] store_pz [N_SLOTS];
    logic [8:0]         point_count_q;

    // Stimulus-side bookkeeping: which slots have been loaded, and the
    // point_count the generator believes is in force.
    bit  loaded [N_SLOTS];
    int  gen_count;

    t_out_res awaited_points [$];
    t_hint    typed_results [$];
    t_step    plan [$];

    int  n_sent;
    int  n_checked;
    int  n_loads;
    int  n_evals;
    int  n_settings;
    int  errors;
    int  quiet;
    int  burst_left;
    int  status_seen [4];
    bit  hold_request;

    catmull_rom_spline_point_evaluator_top #(
        .MAX_POINTS(N_SLOTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_stall (req_stall),
        .i_in_req   (req_data),
        .o_out_valid(res_valid),
        .i_out_stall(res_stall),
        .o_out_res  (res_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Map t onto a segment of the point list: the four window slots and the
    // local fraction u in Q1.16. Past the last segment the index is pulled
    // back and u becomes exactly one.
    function automatic void locate(input logic [T_W-1:0] t, input int eff,
                                   output int w0, output int w1, output int w2,
                                   output int w3, output longint u);
        int     n;
        longint s;
        n  = eff - 1;
        s  = longint'(t) * n;
        w1 = int'(s >>> FRAC_W);
        u  = s & 64'hFFFF;
        if (w1 > n - 1) begin
            w1 = n - 1;
            u  = 64'd65536;
        end
        w0 = (w1 > 0) ? w1 - 1 : 0;
        w2 = w1 + 1;
        w3 = (w1 + 2 > n) ? n : w1 + 2;
    endfunction

    // Uniform Catmull-Rom on one coordinate. The coefficients are kept doubled
    // so they stay integers; the final halving and every Horner shift floor.
    function automatic logic signed [31:0] blend(input longint p0, input longint p1,
                                                 input longint p2, input longint p3,
                                                 input longint u);
        longint ca;
        longint cb;
        longint cc;
        longint h;
        longint v;
        ca = -p0 + 3 * p1 - 3 * p2 + p3;
        cb = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        cc = p2 - p0;
        h  = ((ca * u) >>> FRAC_W) + cb;
        h  = ((h * u) >>> FRAC_W) + cc;
        h  = (h * u) >>> FRAC_W;
        v  = p1 + (h >>> 1);
        if (v > Q_MAX)
            v = Q_MAX;
        if (v < Q_MIN)
            v = Q_MIN;
        return v[31:0];
    endfunction

    // Apply one accepted request to the predictor state and return the result
    // it must produce.
    function automatic t_out_res evaluate_spline_request(input t_in_req r);
        t_out_res res;
        int       eff;
        int       w0;
        int       w1;
        int       w2;
        int       w3;
        longint   u;
        res = '0;
        eff = (point_count_q > N_SLOTS) ? N_SLOTS : int'(point_count_q);
        if (r.action == ACT_LOAD) begin
            if (r.point_index >= N_SLOTS) begin
                res.status = ST_BAD_INDEX;
            end else begin
                store_px[r.point_index] = r.point_x;
                store_py[r.point_index] = r.point_y;
                store_pz[r.point_index] = r.point_z;
            end
        end else if (r.curve_param > ONE_Q16) begin
            res.status = ST_T_HIGH;
        end else if (eff < MIN_POINTS) begin
            res.status = ST_FEW_POINTS;
        end else begin
            locate(r.curve_param, eff, w0, w1, w2, w3, u);
            res.out_x  = blend(store_px[w0], store_px[w1], store_px[w2], store_px[w3], u);
            res.out_y  = blend(store_py[w0], store_py[w1], store_py[w2], store_py[w3], u);
            res.out_z  = blend(store_pz[w0], store_pz[w1], store_pz[w2], store_pz[w3], u);
            res.status = ST_OK;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_in_req load_req(input logic [8:0] slot, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
        t_in_req r;
        r             = '0;
        r.action      = ACT_LOAD;
        r.point_index = slot;
        r.point_x     = x;
        r.point_y     = y;
        r.point_z     = z;
        return r;
    endfunction

    function automatic t_in_req eval_req(input logic [T_W-1:0] t);
        t_in_req r;
        r             = '0;
        r.action      = ACT_EVAL;
        r.curve_param = t;
        return r;
    endfunction

    // A typed result: given coordinates and status.
    function automatic t_hint typed(input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input t_status st);
        t_hint h;
        h.known      = 1'b1;
        h.res.out_x  = x;
        h.res.out_y  = y;
        h.res.out_z  = z;
        h.res.status = st;
        return h;
    endfunction

    task automatic add_request(input t_in_req r, input t_hint h);
        t_step s;
        s        = '0;
        s.req    = r;
        s.hint   = h;
        plan     = {plan, s};
    endtask

    task automatic add_count(input logic [8:0] v);
        t_step s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.cfg    = v;
        plan     = {plan, s};
    endtask

    // Coordinates: full-range words, small values around the origin, the
    // extremes, and a middle band.
    function automatic logic signed [31:0] random_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return $urandom();
        else if (roll < 65)
            return int'($urandom_range(0, 32'h80000)) - 32'sh40000;
        else if (roll < 80)
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        else
            return int'($urandom_range(0, 32'h200_0000)) - 32'sh100_0000;
    endfunction

    // A random request. An evaluation whose window would touch a slot that was
    // never loaded is turned into a load of that slot, so the store is filled
    // on demand and no undefined entry is ever read.
    function automatic t_in_req random_request();
        t_in_req r;
        int      roll;
        int      eff;
        int      span;
        int      w [4];
        longint  u;
        eff           = (gen_count > N_SLOTS) ? N_SLOTS : gen_count;
        span          = (eff > 8) ? eff : 8;
        r.action      = ($urandom_range(0, 99) < 55) ? ACT_EVAL : ACT_LOAD;
        r.point_x     = random_coord();
        r.point_y     = random_coord();
        r.point_z     = random_coord();
        r.curve_param = 17'($urandom_range(0, 131071));
        roll          = $urandom_range(0, 99);
        if (roll < 85)
            r.point_index = 9'($urandom_range(0, span - 1));
        else if (roll < 95)
            r.point_index = 9'($urandom_range(N_SLOTS, 511));
        else
            r.point_index = 9'($urandom_range(0, 511));
        if (r.action == ACT_EVAL) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                r.curve_param = '0;
            else if (roll < 16)
                r.curve_param = ONE_Q16;
            else if (roll < 26)
                r.curve_param = 17'($urandom_range(65537, 131071));
            else
                r.curve_param = 17'($urandom_range(0, 65535));
            if (r.curve_param <= ONE_Q16 && eff >= MIN_POINTS) begin
                locate(r.curve_param, eff, w[0], w[1], w[2], w[3], u);
                for (int k = 3; k >= 0; k--) begin
                    if (!loaded[w[k]]) begin
                        r.action      = ACT_LOAD;
                        r.point_index = 9'(w[k]);
                    end
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side driving
    // ------------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. The typed
    // result, if any, is queued now and picked up by the monitor at the
    // acceptance edge; requests are taken in order, so the two stay aligned.
    task automatic send_request(input t_in_req r, input t_hint h);
        req_valid <= 1'b1;
        req_data  <= r;
        typed_results = {typed_results, h};
        if (r.action == ACT_LOAD && r.point_index < N_SLOTS)
            loaded[r.point_index] = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        n_sent++;
    endtask

    // Gap after a request: usually none or short, sometimes long, and
    // now and then a burst of back-to-back requests.
    task automatic next_gap();
        int roll;
        int n;
        n = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                burst_left = $urandom_range(15, 30);
            else if (roll < 55)
                n = 0;
            else if (roll < 85)
                n = $urandom_range(1, 3);
            else if (roll < 97)
                n = $urandom_range(4, 12);
            else
                n = $urandom_range(20, 40);
        end
        if (n > 0) begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop offering requests and wait until every result has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        while (n_checked != n_sent)
            @(posedge clk);
    endtask

    // point_count is only written with the pipeline empty. Every request
    // yields a result, so an empty result queue means the block is idle.
    task automatic write_point_count(input logic [8:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        gen_count = int'(v);
        n_settings++;
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predicts at request acceptance, checks at result acceptance.
    // Signals are sampled at the rising edge before any driver update of the
    // same edge lands, so no check depends on event order within the step.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_out_res predicted;
        t_out_res want;
        t_hint    h;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                point_count_q = cfg_data;
            if (req_valid && !req_stall) begin
                predicted = evaluate_spline_request(req_data);
                h         = typed_results.pop_front();
                if (h.known)
                    predicted = h.res;
                awaited_points = {awaited_points, predicted};
                if (req_data.action == ACT_LOAD)
                    n_loads++;
                else
                    n_evals++;
            end
            if (res_valid && !res_stall) begin
                if (awaited_points.size() == 0) begin
                    $display("%0t: unexpected result, got %h", $time, res_data);
                    errors++;
                end else begin
                    want = awaited_points.pop_front();
                    report_field("out_x", want.out_x, res_data.out_x);
                    report_field("out_y", want.out_y, res_data.out_y);
                    report_field("out_z", want.out_z, res_data.out_z);
                    report_field("status", 32'(want.status), 32'(res_data.status));
                    status_seen[want.status]++;
                    n_checked++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles in which no handshake completes means
    // the block has hung.
    always @(posedge clk) begin : watchdog
        if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stall pattern. Short stalls dominate, with stretches
    // of free flow and a few long stalls. When the stimulus asks for it, the
    // receiver holds off for HOLD_CYCLES while requests keep coming, which
    // fills the pipeline and must push the stall back to the request side.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int roll;
        int len;
        int c;
        res_stall = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_request) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    res_stall <= 1'b0;
                    len = $urandom_range(1, 8);
                end else if (roll < 90) begin
                    res_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else if (roll < 97) begin
                    res_stall <= 1'b0;
                    len = $urandom_range(20, 40);
                end else begin
                    res_stall <= 1'b1;
                    len = $urandom_range(15, 40);
                end
                c = 0;
                do begin
                    @(posedge clk);
                    c++;
                end while (c < len && !hold_request);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_hint no_hint;
        no_hint       = '0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_data      = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        point_count_q = '0;
        gen_count     = 0;
        hold_request  = 1'b0;
        burst_left    = 0;

        // Directed table. With point_count at its reset value of zero every
        // evaluation is refused; a parameter above one is reported ahead of
        // the point count. Loads at or past capacity are refused and must not
        // touch the store.
        add_request(eval_req(17'h00000), typed(0, 0, 0, ST_FEW_POINTS));
        add_request(eval_req(17'h1FFFF), typed(0, 0, 0, ST_T_HIGH));
        add_request(eval_req(17'h10001), typed(0, 0, 0, ST_T_HIGH));
        add_request(load_req(9'd256, 32'h1, 32'h2, 32'h3), typed(0, 0, 0, ST_BAD_INDEX));
        add_request(load_req(9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                    typed(0, 0, 0, ST_BAD_INDEX));
        // Four points with extreme coordinates so that the cubic saturates.
        add_request(load_req(9'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000),
                    typed(0, 0, 0, ST_OK));
        add_request(load_req(9'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001),
                    typed(0, 0, 0, ST_OK));
        add_request(load_req(9'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
                    typed(0, 0, 0, ST_OK));
        add_request(load_req(9'd3, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF),
                    typed(0, 0, 0, ST_OK));
        // Three points is still too few.
        add_count(9'd3);
        add_request(eval_req(17'h08000), typed(0, 0, 0, ST_FEW_POINTS));
        // Four points: t = 0 lands exactly on the first point and t = 1 on
        // the last one, where the segment index is clamped and u is one.
        add_count(9'd4);
        add_request(eval_req(17'h00000),
                    typed(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, ST_OK));
        add_request(eval_req(17'h10000),
                    typed(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, ST_OK));
        add_request(eval_req(17'h05555), no_hint);
        add_request(eval_req(17'h08000), no_hint);
        add_request(eval_req(17'h0FFFF), no_hint);
        add_request(load_req(9'd4, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000),
                    typed(0, 0, 0, ST_OK));
        // Five points: a knot with u of zero returns that point exactly.
        add_count(9'd5);
        add_request(eval_req(17'h04000),
                    typed(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, ST_OK));
        add_request(eval_req(17'h0C001), no_hint);
        add_request(eval_req(17'h10000),
                    typed(32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000, ST_OK));
        add_request(load_req(9'd255, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F),
                    typed(0, 0, 0, ST_OK));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_point_count(plan[i].cfg);
            end else begin
                send_request(plan[i].req, plan[i].hint);
                next_gap();
            end
        end

        // Random phases, one per point_count setting.
        for (int p = 0; p < N_PHASES; p++) begin
            write_point_count(9'(PHASE_COUNT[p]));
            for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
                // Long receiver hold-off with the sender pushing back to back.
                if (p == 5 && k == 5) begin
                    hold_request = 1'b1;
                    burst_left   = 60;
                end
                // Sender pause until every outstanding result is in.
                if (p == 7 && k == 30)
                    drain_results();
                send_request(random_request(), no_hint);
                next_gap();
            end
        end

        drain_results();
        repeat (LATENCY + 10) @(posedge clk);
        if (awaited_points.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, awaited_points.size());
            errors++;
        end

        $display("Covered %0d loads and %0d evaluations over %0d point_count settings.",
                 n_loads, n_evals, n_settings);
        $display("Results by status: ok %0d, t above one %0d, too few points %0d, bad slot %0d.",
                 status_seen[ST_OK], status_seen[ST_T_HIGH],
                 status_seen[ST_FEW_POINTS], status_seen[ST_BAD_INDEX]);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
